/* design/consonant_shrink_crossfade_core_defines.svh */
// ------------------------------------------------------------------------
// consonant shrink crossfade core: assertion macros
// shared property forms for the checker, same-cycle and next-cycle
// ------------------------------------------------------------------------
`ifndef CONSONANT_SHRINK_CROSSFADE_CORE_DEFINES_SVH
`define CONSONANT_SHRINK_CROSSFADE_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CSC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/csc_pkg.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// csc_pkg
// shared types and constants of the consonant shrink crossfade core
// ------------------------------------------------------------------------
package csc_pkg;

	// consonant length, index and crossfade weights
	localparam int WEIGHT_BITS   = 16;
	localparam int SHRINK_BITS   = 13;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS  = 1;

	typedef logic [WEIGHT_BITS-1:0] weight_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SHRINK_LEN    = 1'b0,
		REG_CONSONANT_LEN = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MAC,
		ST_DIV,
		ST_EMIT
	} state_t;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

/* design/csc_ram.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// csc_ram
// generic simple dual-port ram, one write port, registered read port
// ------------------------------------------------------------------------
module csc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

/* design/csc_mac.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// csc_mac
// bit-serial weighted sum a*wa + x*wb, one weight bit per cycle, msb first
// ------------------------------------------------------------------------
module csc_mac import csc_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          start,
	input  logic signed [SAMPLE_BITS-1:0]                 a,
	input  logic signed [SAMPLE_BITS-1:0]                 x,
	input  weight_t                                       wa,
	input  weight_t                                       wb,
	output unit_sts_t                                     sts,
	output logic signed [SAMPLE_BITS+WEIGHT_BITS:0]       acc
);

	localparam int ACC_BITS = SAMPLE_BITS + WEIGHT_BITS + 1;
	localparam int CNT_BITS = $clog2(WEIGHT_BITS);

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_BITS-1:0]          cnt_q;
	logic signed [SAMPLE_BITS-1:0] a_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	weight_t                      wa_q;
	weight_t                      wb_q;
	logic signed [ACC_BITS-1:0]   acc_q;
	logic signed [ACC_BITS-1:0]   term_a;
	logic signed [ACC_BITS-1:0]   term_b;
	logic signed [ACC_BITS-1:0]   acc_next;
	logic                         last_step;

	always_comb begin
		term_a    = wa_q[WEIGHT_BITS-1] ? ACC_BITS'(a_q) : '0;
		term_b    = wb_q[WEIGHT_BITS-1] ? ACC_BITS'(x_q) : '0;
		acc_next  = (acc_q <<< 1) + term_a + term_b;
		last_step = (cnt_q == CNT_BITS'(WEIGHT_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			x_q   <= x;
			wa_q  <= wa;
			wb_q  <= wb;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_next;
			wa_q  <= wa_q << 1;
			wb_q  <= wb_q << 1;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign acc      = acc_q;

endmodule

/* design/csc_div.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// csc_div
// restoring serial divider, one quotient bit per cycle, then round to
// nearest (ties away from zero), restore sign and saturate
// ------------------------------------------------------------------------
module csc_div import csc_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic signed [SAMPLE_BITS+WEIGHT_BITS:0] num,
	input  weight_t                                 den,
	output unit_sts_t                               sts,
	output logic signed [SAMPLE_BITS-1:0]           quo
);

	localparam int ACC_BITS = SAMPLE_BITS + WEIGHT_BITS + 1;
	localparam int CNT_BITS = $clog2(SAMPLE_BITS);
	localparam logic signed [SAMPLE_BITS+1:0] SAT_HI = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS+1:0] SAT_LO = {3'b111, {(SAMPLE_BITS-1){1'b0}}};

	logic                          busy_q;
	logic                          fin_q;
	logic                          done_q;
	logic [CNT_BITS-1:0]           cnt_q;
	logic                          neg_q;
	weight_t                       den_q;
	weight_t                       rem_q;
	logic [SAMPLE_BITS-1:0]        lo_q;
	logic [SAMPLE_BITS-1:0]        q_q;
	logic signed [SAMPLE_BITS-1:0] quo_q;

	logic [ACC_BITS-1:0]           mag;
	logic [WEIGHT_BITS:0]          trial;
	logic [WEIGHT_BITS:0]          trial_sub;
	logic                          ge;
	logic                          round_up;
	logic [SAMPLE_BITS:0]          q_round;
	logic signed [SAMPLE_BITS+1:0] q_signed;
	logic signed [SAMPLE_BITS-1:0] q_sat;
	logic                          last_step;

	always_comb begin
		mag       = num[ACC_BITS-1] ? ACC_BITS'(-num) : ACC_BITS'(num);
		trial     = {rem_q, lo_q[SAMPLE_BITS-1]};
		trial_sub = trial - {1'b0, den_q};
		ge        = (trial >= {1'b0, den_q});
		last_step = (cnt_q == CNT_BITS'(SAMPLE_BITS - 1));
		// round up when twice the remainder reaches the divisor
		round_up  = ({rem_q, 1'b0} >= {1'b0, den_q});
		q_round   = {1'b0, q_q} + {{SAMPLE_BITS{1'b0}}, round_up};
		q_signed  = neg_q ? -$signed({1'b0, q_round}) : $signed({1'b0, q_round});
		if (q_signed > SAT_HI) begin
			q_sat = SAT_HI[SAMPLE_BITS-1:0];
		end else if (q_signed < SAT_LO) begin
			q_sat = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			q_sat = q_signed[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q  <= busy_q && last_step;
			done_q <= fin_q;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[ACC_BITS-1];
			den_q <= den;
			// upper part is below the divisor, so the quotient fits in the sample width
			rem_q <= mag[SAMPLE_BITS+WEIGHT_BITS-1:SAMPLE_BITS];
			lo_q  <= mag[SAMPLE_BITS-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[WEIGHT_BITS-1:0] : trial[WEIGHT_BITS-1:0];
			lo_q  <= lo_q << 1;
			q_q   <= {q_q[SAMPLE_BITS-2:0], ge};
		end
		if (fin_q) begin
			quo_q <= q_sat;
		end
	end

	assign sts.busy = busy_q || fin_q;
	assign sts.done = done_q;
	assign quo      = quo_q;

endmodule

/* design/consonant_shrink_crossfade_core.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// consonant_shrink_crossfade_core
// shortens the consonant head of a sample segment with a linear crossfade
// ------------------------------------------------------------------------
// Samples of a segment enter in order; seg_end marks the last one and
// restarts the index. The shrink S is shrink_len clamped to half of
// consonant_len and to MAX_SHRINK; the first S samples are only stored in a
// delay ram and give no beat. For S <= n < consonant_len the result is
// (x[n-S]*(D-k) + x[n]*k)/D with k = n-S and D = consonant_len-S-1, rounded
// to nearest with ties away from zero and saturated. Later samples, and all
// samples when consonant_len is 0, S is 0 or D is 0, pass through. A
// dropped sample is only stored, a passed sample goes through the emit
// step into the output register, and a crossfaded sample goes through the
// fetch, weighted-sum, divide and emit steps into the output register. The
// bit-serial weighted sum takes one weight bit per cycle and the serial
// divider one quotient bit per cycle, followed by rounding and handoff. A
// stalled result holds the block in its last step. One item is in flight at
// a time; the next beat is taken as soon as the result sits in the output
// register, even if that beat is not yet taken downstream. The delay ram
// needs no clearing after reset. Registers should be written only while no
// item is in flight; a write applies to the next sample.
// ------------------------------------------------------------------------
module consonant_shrink_crossfade_core import csc_pkg::*; #(
	parameter int MAX_SHRINK  = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// register writes
	input  logic                          cfg_we,
	input  logic [CFG_IDX_BITS-1:0]       cfg_addr,
	input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
	// sample input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          seg_end,
	// sample output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          out_last
);

	localparam int ADDR_BITS = (MAX_SHRINK > 1) ? $clog2(MAX_SHRINK) : 1;
	localparam int ACC_BITS  = SAMPLE_BITS + WEIGHT_BITS + 1;
	localparam int PTR_BITS  = 18;

	// configuration
	logic [SHRINK_BITS-1:0]        shrink_q;
	weight_t                       cons_q;

	// segment position and delay write pointer (index modulo ram depth)
	weight_t                       n_q;
	logic [ADDR_BITS-1:0]          wptr_q;

	state_t                        state_q;
	state_t                        state_d;

	// item in flight
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic                          last_q;
	weight_t                       wa_q;
	weight_t                       k_q;
	weight_t                       d_q;

	// output register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;
	logic                          out_last_q;

	// per-sample decode
	weight_t                       half_c;
	weight_t                       s_min;
	weight_t                       s_eff;
	weight_t                       r_val;
	weight_t                       k_val;
	weight_t                       d_val;
	logic                          bypass;
	logic                          drop;
	logic [PTR_BITS-1:0]           rdiff;
	logic [PTR_BITS-1:0]           rwrap;
	logic [ADDR_BITS-1:0]          raddr;
	logic                          accept;

	// fsm outputs
	logic                          mac_start;
	logic                          div_start;
	logic                          emit_load;

	// unit links
	logic [SAMPLE_BITS-1:0]        ram_rdata;
	unit_sts_t                     mac_sts;
	unit_sts_t                     div_sts;
	logic signed [ACC_BITS-1:0]    mac_acc;
	logic signed [SAMPLE_BITS-1:0] div_quo;

	// clamp the shrink and classify the sample
	always_comb begin
		half_c = cons_q >> 1;
		s_min  = ({3'b000, shrink_q} < half_c) ? {3'b000, shrink_q} : half_c;
		s_eff  = (17'(s_min) > 17'(MAX_SHRINK)) ? WEIGHT_BITS'(MAX_SHRINK) : s_min;
		r_val  = cons_q - s_eff;
		k_val  = n_q - s_eff;
		d_val  = r_val - 1'b1;
		bypass = (cons_q == '0) || (s_eff == '0) || (r_val == WEIGHT_BITS'(1))
			|| (n_q >= cons_q);
		drop   = !bypass && (n_q < s_eff);
		// delayed sample sits S places behind the write pointer, modulo depth
		rdiff  = PTR_BITS'(wptr_q) - PTR_BITS'(s_eff);
		rwrap  = rdiff[PTR_BITS-1] ? (rdiff + PTR_BITS'(MAX_SHRINK)) : rdiff;
		raddr  = rwrap[ADDR_BITS-1:0];
	end

	assign accept = in_valid && in_ready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shrink_q <= '0;
			cons_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_SHRINK_LEN: begin
					shrink_q <= cfg_wdata[SHRINK_BITS-1:0];
				end
				REG_CONSONANT_LEN: begin
					cons_q <= cfg_wdata[WEIGHT_BITS-1:0];
				end
				default: begin
					shrink_q <= shrink_q;
				end
			endcase
		end
	end

	// segment index, saturates at all ones where every sample passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			wptr_q <= '0;
		end else if (accept) begin
			if (seg_end) begin
				n_q    <= '0;
				wptr_q <= '0;
			end else if (n_q != '1) begin
				n_q    <= n_q + 1'b1;
				wptr_q <= (wptr_q == ADDR_BITS'(MAX_SHRINK - 1)) ? '0 : wptr_q + 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mac_start = 1'b0;
		div_start = 1'b0;
		emit_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (bypass) begin
						state_d = ST_EMIT;
					end else if (drop) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				// delayed sample is on the ram read port now
				if (!mac_sts.busy) begin
					mac_start = 1'b1;
					state_d   = ST_MAC;
				end
			end
			ST_MAC: begin
				if (mac_sts.done && !div_sts.busy) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_sts.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit_load = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= sample_in;
			y_q    <= sample_in;
			last_q <= seg_end;
			wa_q   <= d_val - k_val;
			k_q    <= k_val;
			d_q    <= d_val;
		end else if ((state_q == ST_DIV) && div_sts.done) begin
			y_q <= div_quo;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_data_q <= y_q;
			out_last_q <= last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_data_q;
	assign out_last   = out_last_q;

	// delay line: head samples and crossfaded samples are stored
	csc_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_SHRINK)
	) u_delay (
		.clk   (clk),
		.we    (accept && !bypass),
		.waddr (wptr_q),
		.wdata (sample_in),
		.re    (accept),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// numerator: a*(D-k) + x*k
	csc_mac #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.a      ($signed(ram_rdata)),
		.x      (x_q),
		.wa     (wa_q),
		.wb     (k_q),
		.sts    (mac_sts),
		.acc    (mac_acc)
	);

	// divide by D with rounding and saturation
	csc_div #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mac_acc),
		.den    (d_q),
		.sts    (div_sts),
		.quo    (div_quo)
	);

endmodule

/* design/csc_checker.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// csc_checker
// port-level checks of the consonant shrink crossfade core
// ------------------------------------------------------------------------
`include "consonant_shrink_crossfade_core_defines.svh"

module csc_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] sample_out,
	input logic                   out_last
);

	// a waiting result beat holds
	`CSC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(out_last), "result beat changed while stalled")

	// the input side only closes after taking a beat
	`CSC_ASSERT_SAME(a_ready_fall, clk, arst_n, $fell(in_ready), $past(in_valid && in_ready), "input closed without a beat")

	// an idle block stays open
	`CSC_ASSERT_NEXT(a_idle_open, clk, arst_n, in_ready && !in_valid, in_ready, "input closed while idle")

	// a result is loaded only while the input side is closed
	`CSC_ASSERT_SAME(a_emit_busy, clk, arst_n, $rose(out_valid), !$past(in_ready), "result appeared while idle")

endmodule

bind consonant_shrink_crossfade_core csc_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_csc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sample_out (sample_out),
	.out_last   (out_last)
);

/* test/tb_consonant_shrink_crossfade_core.sv */
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb_consonant_shrink_crossfade_core
// drives sample segments through the consonant shrink crossfade core and
// checks every output beat against an in-bench prediction of the splice
// ------------------------------------------------------------------------
// A short directed pass covers the field extremes, rounding ties, a segment
// that ends inside the dropped head and every bypass condition. Random
// phases then reprogram both registers and send mostly well-formed
// segments, with some cut short. One random phase runs with no idling on
// either side, another holds the output off for a long stretch while the
// input keeps offering.
// ------------------------------------------------------------------------
module tb_consonant_shrink_crossfade_core;
	import csc_pkg::*;

	localparam int SAMPLE_BITS  = 16;
	localparam int DELAY_DEPTH  = 4096;
	localparam int RANDOM_ITEMS = 1600;
	localparam int DRAIN_PAUSE  = 60;
	localparam int CYCLE_LIMIT  = 8_000_000;
	localparam int MAX_REPORTS  = 10;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t smp;
		logic    last;
	} out_beat_t;

	// --------------------------------------------------------------------
	// splice predictor and queue of expected output beats
	// --------------------------------------------------------------------
	class splice_scoreboard;
		logic [SHRINK_BITS-1:0] shrink_len;
		logic [15:0]            consonant_len;
		sample_t                history [DELAY_DEPTH];
		logic [15:0]            seg_pos;
		out_beat_t              splice_q [$];
		int                     mismatches;

		function new();
			shrink_len    = '0;
			consonant_len = '0;
			seg_pos       = '0;
			mismatches    = 0;
			foreach (history[i])
				history[i] = '0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [15:0] val);
			if (idx == REG_SHRINK_LEN)
				shrink_len = val[SHRINK_BITS-1:0];
			else
				consonant_len = val;
		endfunction

		// one accepted input beat: update state, queue the result if any
		function void note_sample(sample_t x, logic last);
			int unsigned c, s, r, n;
			longint      xl, a, d, k, num, y;
			bit          emit;
			out_beat_t   b;
			c    = consonant_len;
			s    = shrink_len;
			n    = seg_pos;
			xl   = x;
			y    = xl;
			emit = 1'b1;
			if (s > c / 2)
				s = c / 2;
			if (s > DELAY_DEPTH)
				s = DELAY_DEPTH;
			r = c - s;
			if (c == 0 || s == 0 || r == 1 || n >= c) begin
				y = xl;
			end else if (n < s) begin
				history[n % DELAY_DEPTH] = x;
				emit = 1'b0;
			end else begin
				a   = history[(n - s) % DELAY_DEPTH];
				d   = longint'(r) - 1;
				k   = longint'(n - s);
				history[n % DELAY_DEPTH] = x;
				num = a * (d - k) + xl * k;
				// round to nearest, ties away from zero
				if (num >= 0)
					y = (2 * num + d) / (2 * d);
				else
					y = -((-2 * num + d) / (2 * d));
				if (y > 32767)
					y = 32767;
				if (y < -32768)
					y = -32768;
			end
			if (last)
				seg_pos = '0;
			else if (seg_pos != 16'hFFFF)
				seg_pos = seg_pos + 16'd1;
			if (emit) begin
				b.smp  = y[SAMPLE_BITS-1:0];
				b.last = last;
				splice_q.push_back(b);
			end
		endfunction

		function void check_beat(sample_t got_smp, logic got_last);
			out_beat_t b;
			if (splice_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected beat: sample %0d last %0b", got_smp, got_last);
				return;
			end
			b = splice_q.pop_front();
			if (b.smp !== got_smp || b.last !== got_last) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch: expected sample %0d last %0b, got sample %0d last %0b",
						b.smp, b.last, got_smp, got_last);
			end
		endfunction

		function int pending();
			return splice_q.size();
		endfunction
	endclass

	// --------------------------------------------------------------------
	// clock, reset and block inputs, all known from time zero
	// --------------------------------------------------------------------
	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_addr  = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	sample_t                 sample_in = '0;
	logic                    seg_end   = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	sample_t                 sample_out;
	logic                    out_last;

	splice_scoreboard sb = new();

	// calm suppresses idling on both sides; hold_left is the output hold-off
	bit          calm       = 1'b0;
	int          hold_left  = 0;
	int unsigned beats_sent = 0;

	always #5 clk = ~clk;

	consonant_shrink_crossfade_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.seg_end    (seg_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.out_last   (out_last)
	);

	// --------------------------------------------------------------------
	// input side
	// --------------------------------------------------------------------

	// offer one beat after a random gap; returns on the edge that takes it
	task automatic push_sample(sample_t x, logic last);
		while (!calm && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= x;
		seg_end   <= last;
		// handshake signals read here still hold their pre-edge values
		do @(posedge clk); while (!in_ready);
		sb.note_sample(x, last);
		beats_sent++;
	endtask

	function automatic sample_t rand_sample();
		int unsigned bits;
		bits = $urandom();
		case ($urandom_range(9))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return '0;
			3:       return '1;
			default: return bits[SAMPLE_BITS-1:0];
		endcase
	endfunction

	// a segment of random samples, seg_end on the last one
	task automatic send_segment(int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			push_sample(rand_sample(), i == len - 1);
	endtask

	// stop offering, wait for every expected beat, then let the core go idle
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// both registers, one write per cycle; only called with the core idle
	task automatic program_regs(logic [15:0] shrink, logic [15:0] cons);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_SHRINK_LEN;
		cfg_wdata <= shrink;
		@(posedge clk);
		sb.write_reg(REG_SHRINK_LEN, shrink);
		cfg_addr  <= REG_CONSONANT_LEN;
		cfg_wdata <= cons;
		@(posedge clk);
		sb.write_reg(REG_CONSONANT_LEN, cons);
		cfg_we    <= 1'b0;
	endtask

	// one random setting and a burst of segments under it
	task automatic random_phase(int unsigned idx);
		logic [15:0] shrink, cons;
		int unsigned s_eff, budget, len, start;
		case ($urandom_range(7))
			0:       shrink = 16'd0;
			1:       shrink = 16'd1;
			2:       shrink = 16'd4096;
			3:       shrink = 16'd8191;
			4, 5:    shrink = 16'($urandom_range(1, 40));
			6:       shrink = 16'($urandom_range(0, 8191));
			default: shrink = 16'($urandom_range(2, 12));
		endcase
		case ($urandom_range(9))
			0:       cons = 16'd0;
			1:       cons = 16'd1;
			2:       cons = 16'd2;
			3:       cons = 16'd3;
			4:       cons = 16'd65535;
			5:       cons = 16'($urandom_range(4096, 65535));
			default: cons = 16'($urandom_range(4, 90));
		endcase
		// long consonants keep a short head so crossfades are still reached
		if (cons > 200 && shrink > 64)
			shrink = 16'($urandom_range(1, 64));
		s_eff = shrink;
		if (s_eff > cons / 2)
			s_eff = cons / 2;
		if (s_eff > DELAY_DEPTH)
			s_eff = DELAY_DEPTH;
		settle();
		program_regs(shrink, cons);
		// one phase with no idling on either side
		calm = (idx == 1);
		// one long output hold-off while the input keeps offering
		if (idx == 2)
			hold_left = 400;
		start  = beats_sent;
		budget = $urandom_range(80, 220);
		while (beats_sent - start < budget) begin
			case ($urandom_range(9))
				// cut short, often inside the dropped head
				0, 1:    len = $urandom_range(1, s_eff + 1);
				default: len = (cons <= 200) ? cons + $urandom_range(0, 12)
				                             : $urandom_range(1, 120);
			endcase
			if (len == 0)
				len = 1;
			send_segment(len);
		end
		calm = 1'b0;
	endtask

	// --------------------------------------------------------------------
	// output side: check accepted beats, then pick next ready
	// --------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_beat(sample_out, out_last);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 23);
			end
		end
	end

	// --------------------------------------------------------------------
	// run limit
	// --------------------------------------------------------------------
	initial begin
		for (int cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// --------------------------------------------------------------------
	// main sequence
	// --------------------------------------------------------------------
	initial begin
		// crossfade with an even divisor, so ties of both signs show up
		sample_t head_pat [9];
		int unsigned phase_no;
		int unsigned start;

		head_pat = '{16'sd5, 16'sd0, 16'sd0, 16'sd2, -16'sd1,
		             16'h7FFF, 16'h8000, 16'sd100, -16'sd200};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shrink 2 of 7: two dropped, five crossfaded, then pass through
		program_regs(16'd2, 16'd7);
		foreach (head_pat[i])
			push_sample(head_pat[i], i == 8);
		// segment that ends inside the dropped head: no beat at all
		push_sample(16'sd9, 1'b1);
		settle();

		// bypass: zero shrink
		program_regs(16'd0, 16'd10);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h7FFF, 1'b1);
		settle();

		// bypass: crossfade span of one
		program_regs(16'd1, 16'd2);
		push_sample(-16'sd3, 1'b0);
		push_sample(16'sd3, 1'b1);
		settle();

		// shrink clamped to half the consonant
		program_regs(16'd4096, 16'd5);
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'sd1, 1'b0);
		push_sample(-16'sd1, 1'b1);
		settle();

		// bypass: vowel
		program_regs(16'd5, 16'd0);
		push_sample(16'sd77, 1'b0);
		push_sample(-16'sd77, 1'b1);

		// random settings and segments
		phase_no = 0;
		start    = beats_sent;
		while (beats_sent - start < RANDOM_ITEMS) begin
			random_phase(phase_no);
			phase_no++;
		end

		settle();
		if (sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
